// ===== sv/mesh_neighbor_table_macros.svh =====
// Assertion macros shared by the neighbor table RTL.
`ifndef MESH_NEIGHBOR_TABLE_MACROS_SVH
`define MESH_NEIGHBOR_TABLE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is low.
`define MNT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neighbor table check failed");

// Next-cycle implication, disabled while reset is low.
`define MNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neighbor table check failed");

`else

`define MNT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MNT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mnt_pkg.sv =====
package mnt_pkg;

    // Record modes on the input channel
    localparam logic [1:0] MODE_SOURCE = 2'd0;
    localparam logic [1:0] MODE_RELAY  = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_UPDATED  = 3'd0,
        ACT_INSERTED = 3'd1,
        ACT_IGNORED  = 3'd2,
        ACT_FULL     = 3'd3,
        ACT_READ     = 3'd4
    } action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } state_t;

    // Where the entry fields of a result come from
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ITEM,
        SRC_RAM
    } entry_src_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  rssi;
        logic [31:0] seen;
        logic [31:0] lat;
        logic [31:0] lon;
    } entry_t;

endpackage

// ===== sv/mnt_ram.sv =====
module mnt_ram #(
    parameter int WIDTH = 136,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mesh_neighbor_table.sv =====
// Mesh neighbor table.
// Input channel (in_valid / in_stall): one record per transfer. Mode 0 is the
// source id of a discovery packet, mode 1 a relayed id of that packet, mode 2
// reads the slot given by read_index. Output channel (out_valid / out_stall):
// exactly one result per record, in order.
// own_node_id is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while the block idles, as the block does not enforce it. Records are
// searched by id through one RAM read port, one entry per cycle, with the
// compare in the cycle after the read. A miss reads every entry before
// appending or reporting a full table; a hit stops at its slot and updates it
// in place; reads and ignored records skip the search. in_stall is high from
// the transfer until the result is handed to the output register, and the next
// transfer can come in the cycle after; the sequential search sets the rate.
// The output register holds a result while out_stall is high; the next record is
// still taken and searched, and waits for that register before finishing.
// Reset empties the table (entry count zero), clears the drop mark and the
// own id; the RAM contents are not cleared, only slots below the count are read.
`include "mesh_neighbor_table_macros.svh"

module mesh_neighbor_table
    import mnt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [31:0]        node_id,
    input  logic [7:0]         hop_ttl,
    input  logic signed [7:0]  signal_rssi,
    input  logic [31:0]        now_ms,
    input  logic [31:0]        lat_bits,
    input  logic [31:0]        lon_bits,
    input  logic [3:0]         read_index,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         action,
    output logic [3:0]         slot,
    output logic               forward,
    output logic [7:0]         forward_ttl,
    output logic [4:0]         entry_count,
    output logic [31:0]        entry_id,
    output logic signed [7:0]  entry_rssi,
    output logic [31:0]        entry_last_seen,
    output logic [31:0]        entry_lat,
    output logic [31:0]        entry_lon
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [AW-1:0]   pidx_reg, pidx_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            dropped_reg, dropped_next;
    logic [31:0]     own_id_reg;
    logic            out_valid_reg, out_valid_next;

    // Working record and partial result
    entry_t          item_reg, item_next;
    logic            fwd_reg, fwd_next;
    logic [7:0]      fwd_ttl_reg, fwd_ttl_next;
    action_t         act_reg, act_next;
    logic [3:0]      slot_reg, slot_next;
    entry_src_t      src_reg, src_next;

    // Output register
    logic            res_load;
    action_t         res_action_reg;
    logic [3:0]      res_slot_reg;
    logic            res_fwd_reg;
    logic [7:0]      res_fwd_ttl_reg;
    logic [4:0]      res_count_reg;
    entry_t          res_entry_reg;
    entry_t          res_entry;

    // RAM port
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_raddr;
    entry_t          ram_rdata;
    logic            accept;
    logic            hit;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign hit      = pend_reg && (ram_rdata.id == item_reg.id);

    mnt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg),
        .rd_en (ram_rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state, search sequencing and result build-up
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        item_next      = item_reg;
        fwd_next       = fwd_reg;
        fwd_ttl_next   = fwd_ttl_reg;
        act_next       = act_reg;
        slot_next      = slot_reg;
        src_next       = src_reg;
        ram_we         = 1'b0;
        ram_waddr      = pidx_reg;
        ram_rd_en      = 1'b0;
        ram_raddr      = idx_reg[AW-1:0];
        res_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next    = '{id: node_id, rssi: signal_rssi, seen: now_ms,
                                     lat: lat_bits, lon: lon_bits};
                    fwd_next     = 1'b0;
                    fwd_ttl_next = '0;
                    act_next     = ACT_IGNORED;
                    slot_next    = '0;
                    src_next     = SRC_ZERO;
                    idx_next     = '0;
                    pend_next    = 1'b0;
                    state_next   = S_DONE;
                    unique case (mode)
                        MODE_SOURCE:
                        begin
                            if (node_id == own_id_reg)
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                dropped_next = 1'b0;
                                fwd_next     = (hop_ttl != 8'd0);
                                fwd_ttl_next = (hop_ttl != 8'd0) ? (hop_ttl - 8'd1) : 8'd0;
                                state_next   = S_SEARCH;
                            end
                        end
                        MODE_RELAY:
                        begin
                            if (!dropped_reg && (node_id != own_id_reg))
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        MODE_READ:
                        begin
                            act_next  = ACT_READ;
                            slot_next = read_index;
                            if (32'(read_index) < 32'(count_reg))
                            begin
                                ram_rd_en = 1'b1;
                                ram_raddr = AW'(read_index);
                                src_next  = SRC_RAM;
                            end
                        end
                        default:
                        begin
                            act_next = ACT_IGNORED;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                pend_next = 1'b0;
                if (hit)
                begin
                    // Update the matching entry in place
                    ram_we     = 1'b1;
                    ram_waddr  = pidx_reg;
                    act_next   = ACT_UPDATED;
                    slot_next  = 4'(pidx_reg);
                    src_next   = SRC_ITEM;
                    state_next = S_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    // Issue the next read; compare it in the next cycle
                    ram_rd_en = 1'b1;
                    ram_raddr = idx_reg[AW-1:0];
                    pend_next = 1'b1;
                    pidx_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                end
                else if (count_reg == CW'(TABLE_DEPTH))
                begin
                    act_next   = ACT_FULL;
                    slot_next  = '0;
                    src_next   = SRC_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    // Append at the end of the table
                    ram_we     = 1'b1;
                    ram_waddr  = count_reg[AW-1:0];
                    act_next   = ACT_INSERTED;
                    slot_next  = 4'(count_reg);
                    src_next   = SRC_ITEM;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Pick the entry fields of the result
    always_comb
    begin
        case (src_reg)
            SRC_ITEM: res_entry = item_reg;
            SRC_RAM:  res_entry = ram_rdata;
            default:  res_entry = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            own_id_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                own_id_reg <= cfg_wr_data;
            end
        end
    end

    // Working and output payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg    <= pidx_next;
        item_reg    <= item_next;
        fwd_reg     <= fwd_next;
        fwd_ttl_reg <= fwd_ttl_next;
        act_reg     <= act_next;
        slot_reg    <= slot_next;
        src_reg     <= src_next;
        if (res_load)
        begin
            res_action_reg  <= act_reg;
            res_slot_reg    <= slot_reg;
            res_fwd_reg     <= fwd_reg;
            res_fwd_ttl_reg <= fwd_ttl_reg;
            res_count_reg   <= 5'(count_reg);
            res_entry_reg   <= res_entry;
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = res_action_reg;
    assign slot            = res_slot_reg;
    assign forward         = res_fwd_reg;
    assign forward_ttl     = res_fwd_ttl_reg;
    assign entry_count     = res_count_reg;
    assign entry_id        = res_entry_reg.id;
    assign entry_rssi      = res_entry_reg.rssi;
    assign entry_last_seen = res_entry_reg.seen;
    assign entry_lat       = res_entry_reg.lat;
    assign entry_lon       = res_entry_reg.lon;

    // Checks
    `MNT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= 32'(TABLE_DEPTH))
    `MNT_ASSERT_IMPL(a_read_in_table, clk, rst_n, ram_rd_en, 32'(ram_raddr) < 32'(count_reg))
    `MNT_ASSERT_NEXT(a_write_in_table, clk, rst_n, ram_we, 32'($past(ram_waddr)) < 32'(count_reg))
    `MNT_ASSERT_IMPL(a_count_step, clk, rst_n, !$stable(count_reg),
                     32'(count_reg) == 32'($past(count_reg)) + 32'd1)
    `MNT_ASSERT_NEXT(a_done_waits, clk, rst_n,
                     (state_reg == S_DONE) && out_valid_reg && out_stall,
                     state_reg == S_DONE)

endmodule

// ===== tb/mesh_neighbor_table_test.sv =====
`timescale 1ns / 100ps

module mesh_neighbor_table_test;
    import mnt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int POOL_SIZE = 20;
    localparam int PW = $clog2(POOL_SIZE);
    localparam int PHASE_RECORDS = 215;
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP = 17;

    localparam logic [31:0] ID_A = 32'h1234_5678;
    localparam logic [31:0] ID_B = 32'hA5C3_0F96;

    typedef struct packed {
        logic [1:0]        mode;
        logic [31:0]       node_id;
        logic [7:0]        hop_ttl;
        logic signed [7:0] rssi;
        logic [31:0]       now_ms;
        logic [31:0]       lat;
        logic [31:0]       lon;
        logic [3:0]        read_index;
    } record_t;

    typedef struct packed {
        action_t           action;
        logic [3:0]        slot;
        logic              forward;
        logic [7:0]        forward_ttl;
        logic [4:0]        entry_count;
        logic [31:0]       id;
        logic signed [7:0] rssi;
        logic [31:0]       last_seen;
        logic [31:0]       lat;
        logic [31:0]       lon;
    } table_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [31:0]        node_id;
    logic [7:0]         hop_ttl;
    logic signed [7:0]  signal_rssi;
    logic [31:0]        now_ms;
    logic [31:0]        lat_bits;
    logic [31:0]        lon_bits;
    logic [3:0]         read_index;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         action;
    logic [3:0]         slot;
    logic               forward;
    logic [7:0]         forward_ttl;
    logic [4:0]         entry_count;
    logic [31:0]        entry_id;
    logic signed [7:0]  entry_rssi;
    logic [31:0]        entry_last_seen;
    logic [31:0]        entry_lat;
    logic [31:0]        entry_lon;

    // Neighbor table as the testbench tracks it
    logic [31:0]        nbr_id   [TABLE_DEPTH];
    logic signed [7:0]  nbr_rssi [TABLE_DEPTH];
    logic [31:0]        nbr_seen [TABLE_DEPTH];
    logic [31:0]        nbr_lat  [TABLE_DEPTH];
    logic [31:0]        nbr_lon  [TABLE_DEPTH];
    int                 nbr_count = 0;
    bit                 drop_mark = 1'b0;
    logic [31:0]        own_id_model = 32'h0;

    table_result_t      expected_results[$];
    logic [31:0]        id_pool[POOL_SIZE];
    bit                 no_idle = 1'b0;
    int                 records_sent = 0;
    int                 useful_records = 0;
    int                 results_checked = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;
    int                 action_tally[8];

    mesh_neighbor_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .node_id(node_id),
        .hop_ttl(hop_ttl),
        .signal_rssi(signal_rssi),
        .now_ms(now_ms),
        .lat_bits(lat_bits),
        .lon_bits(lon_bits),
        .read_index(read_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .action(action),
        .slot(slot),
        .forward(forward),
        .forward_ttl(forward_ttl),
        .entry_count(entry_count),
        .entry_id(entry_id),
        .entry_rssi(entry_rssi),
        .entry_last_seen(entry_last_seen),
        .entry_lat(entry_lat),
        .entry_lon(entry_lon)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // End the run if the traffic never drains
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Apply one record to the tracked table and build the result it should give
    function automatic table_result_t predict_record(record_t r);
        table_result_t res;
        int s;
        bit keep_record;
        res = '0;
        res.action = ACT_IGNORED;
        keep_record = 1'b0;
        s = 0;
        case (r.mode)
            MODE_SOURCE:
            begin
                if (r.node_id == own_id_model)
                    drop_mark = 1'b1;
                else
                begin
                    drop_mark = 1'b0;
                    if (r.hop_ttl != 8'd0)
                    begin
                        res.forward = 1'b1;
                        res.forward_ttl = r.hop_ttl - 8'd1;
                    end
                    keep_record = 1'b1;
                end
            end
            MODE_RELAY:
                keep_record = !drop_mark && (r.node_id != own_id_model);
            MODE_READ:
            begin
                res.action = ACT_READ;
                res.slot = r.read_index;
                s = int'(r.read_index);
            end
            default:
                ;
        endcase

        // Search by id, then update the hit, append the miss or report a full table
        if (keep_record)
        begin
            while (s < nbr_count && nbr_id[IW'(s)] != r.node_id)
                s++;
            if (s == TABLE_DEPTH)
                res.action = ACT_FULL;
            else
            begin
                if (s == nbr_count)
                begin
                    nbr_id[IW'(s)] = r.node_id;
                    nbr_count++;
                    res.action = ACT_INSERTED;
                end
                else
                    res.action = ACT_UPDATED;
                nbr_rssi[IW'(s)] = r.rssi;
                nbr_seen[IW'(s)] = r.now_ms;
                nbr_lat[IW'(s)] = r.lat;
                nbr_lon[IW'(s)] = r.lon;
                res.slot = 4'(s);
            end
        end

        if (res.action == ACT_UPDATED || res.action == ACT_INSERTED ||
            (res.action == ACT_READ && s < nbr_count))
        begin
            res.id = nbr_id[IW'(s)];
            res.rssi = nbr_rssi[IW'(s)];
            res.last_seen = nbr_seen[IW'(s)];
            res.lat = nbr_lat[IW'(s)];
            res.lon = nbr_lon[IW'(s)];
        end
        res.entry_count = 5'(nbr_count);
        return res;
    endfunction

    function automatic record_t random_record();
        record_t r;
        r.mode = 2'($urandom_range(0, 3));
        r.node_id = $urandom;
        r.hop_ttl = 8'($urandom);
        r.rssi = 8'($urandom);
        r.now_ms = $urandom;
        r.lat = $urandom;
        r.lon = $urandom;
        r.read_index = 4'($urandom);
        return r;
    endfunction

    // Offer one record, hold it until the transfer, then record what it should give
    task automatic send_record(record_t r);
        int gap;
        table_result_t res;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= r.mode;
        node_id <= r.node_id;
        hop_ttl <= r.hop_ttl;
        signal_rssi <= r.rssi;
        now_ms <= r.now_ms;
        lat_bits <= r.lat;
        lon_bits <= r.lon;
        read_index <= r.read_index;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_record(r);
        expected_results = {expected_results, res};
        records_sent++;
        if (res.action != ACT_IGNORED)
            useful_records++;
    endtask

    task automatic send_id(logic [1:0] m, logic [31:0] id, logic [7:0] ttl);
        record_t r;
        r = random_record();
        r.mode = m;
        r.node_id = id;
        r.hop_ttl = ttl;
        send_record(r);
    endtask

    task automatic send_read(logic [3:0] index);
        record_t r;
        r = random_record();
        r.mode = MODE_READ;
        r.read_index = index;
        send_record(r);
    endtask

    // Write the own id once the block has drained
    task automatic write_own_id(logic [31:0] value);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        own_id_model = value;
    endtask

    // Out-of-range reads and the reserved mode on an empty table
    task automatic test_empty_reads();
        send_read(4'd0);
        send_read(4'hF);
        send_id(MODE_RESERVED, ID_A, 8'd3);
    endtask

    // Own source sets the drop mark; relayed ids are ignored, reserved mode keeps it
    task automatic test_drop_mark();
        send_id(MODE_SOURCE, 32'h0, 8'd5);
        send_id(MODE_RELAY, ID_A, 8'd3);
        send_id(MODE_RESERVED, ID_B, 8'd0);
        send_id(MODE_RELAY, ID_B, 8'd0);
    endtask

    // Insert, update, own relayed id, TTL and location extremes, then read back
    task automatic test_insert_update();
        record_t r;
        send_id(MODE_SOURCE, ID_A, 8'd0);
        send_id(MODE_RELAY, ID_B, 8'd9);
        send_id(MODE_RELAY, 32'h0, 8'd9);
        r = random_record();
        r.mode = MODE_SOURCE;
        r.node_id = ID_A;
        r.hop_ttl = 8'hFF;
        r.rssi = -8'sd128;
        r.now_ms = 32'h0;
        r.lat = 32'h0;
        r.lon = 32'hFFFF_FFFF;
        send_record(r);
        r.node_id = ID_B;
        r.hop_ttl = 8'd1;
        r.rssi = 8'sd127;
        r.now_ms = 32'hFFFF_FFFF;
        r.lat = 32'hFFFF_FFFF;
        r.lon = 32'h0;
        send_record(r);
        send_id(MODE_RELAY, 32'hFFFF_FFFF, 8'd0);
        for (int i = 0; i < 4; i++)
            send_read(4'(i));
    endtask

    // Own id at its top value
    task automatic test_own_id_max();
        write_own_id(32'hFFFF_FFFF);
        send_id(MODE_SOURCE, 32'hFFFF_FFFF, 8'd7);
        send_id(MODE_RELAY, ID_A, 8'd7);
        send_id(MODE_SOURCE, ID_B, 8'd7);
        send_id(MODE_RELAY, 32'hFFFF_FFFF, 8'd7);
    endtask

    function automatic logic [31:0] pick_id(int own_percent);
        if ($urandom_range(0, 99) < own_percent)
            return own_id_model;
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        return id_pool[PW'($urandom_range(0, POOL_SIZE - 1))];
    endfunction

    // One discovery packet: a source and the relayed ids that follow it
    task automatic send_packet();
        record_t r;
        int relays;
        r = random_record();
        r.mode = MODE_SOURCE;
        r.node_id = pick_id(15);
        case ($urandom_range(0, 7))
            0: r.hop_ttl = 8'd0;
            1: r.hop_ttl = 8'hFF;
            default: ;
        endcase
        send_record(r);
        relays = int'($urandom_range(0, 5));
        repeat (relays)
        begin
            r.mode = MODE_RELAY;
            r.node_id = pick_id(6);
            r.hop_ttl = 8'($urandom);
            r.read_index = 4'($urandom);
            // break the packet now and then with fresh link data
            if ($urandom_range(0, 9) == 0)
                r.now_ms = $urandom;
            send_record(r);
        end
    endtask

    task automatic random_event();
        if ($urandom_range(0, 79) == 0)
            no_idle = !no_idle;
        case ($urandom_range(0, 9))
            0: send_read(4'($urandom));
            1: send_record(random_record());
            2: send_id(MODE_RELAY, pick_id(10), 8'($urandom));
            default: send_packet();
        endcase
    endtask

    // Mostly well-formed packets over four own-id settings
    task automatic test_random_traffic();
        int target;
        logic [31:0] own_value;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        id_pool[2] = ID_A;
        id_pool[3] = ID_B;
        for (int i = 4; i < POOL_SIZE; i++)
            id_pool[PW'(i)] = $urandom;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: own_value = id_pool[5];
                1: own_value = 32'h0;
                2: own_value = 32'hFFFF_FFFF;
                default: own_value = $urandom;
            endcase
            write_own_id(own_value);
            target = useful_records + PHASE_RECORDS;
            while (useful_records < target)
                random_event();
        end
        no_idle = 1'b0;
    endtask

    // Misses on a full table, with and without a forward, then a hit on the last slot
    task automatic test_table_full();
        while (nbr_count < TABLE_DEPTH)
            send_id(MODE_SOURCE, $urandom, 8'($urandom));
        send_id(MODE_SOURCE, $urandom, 8'd9);
        send_id(MODE_RELAY, $urandom, 8'd0);
        send_id(MODE_SOURCE, $urandom, 8'd0);
        send_read(4'hF);
        send_read(4'd0);
        send_id(MODE_RELAY, nbr_id[TABLE_DEPTH - 1], 8'd0);
    endtask

    // Stall the result side for a drawn number of cycles, then take one transfer
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result transfer with the oldest outstanding expectation
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no record outstanding: action %0d", action);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("action", 32'(want.action), 32'(action));
                check_field("slot", 32'(want.slot), 32'(slot));
                check_field("forward", 32'(want.forward), 32'(forward));
                check_field("forward_ttl", 32'(want.forward_ttl), 32'(forward_ttl));
                check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
                check_field("entry_id", want.id, entry_id);
                check_field("entry_rssi", 32'(want.rssi), 32'(entry_rssi));
                check_field("entry_last_seen", want.last_seen, entry_last_seen);
                check_field("entry_lat", want.lat, entry_lat);
                check_field("entry_lon", want.lon, entry_lon);
                action_tally[want.action]++;
                results_checked++;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 32'h0;
        in_valid <= 1'b0;
        mode <= MODE_SOURCE;
        node_id <= 32'h0;
        hop_ttl <= 8'h0;
        signal_rssi <= 8'sh0;
        now_ms <= 32'h0;
        lat_bits <= 32'h0;
        lon_bits <= 32'h0;
        read_index <= 4'h0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_own_id(32'h0);
        test_empty_reads();
        test_drop_mark();
        test_insert_update();
        test_own_id_max();
        test_random_traffic();
        test_table_full();

        // Drain outstanding results
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d records and checked %0d results across six own-id writes.",
                 records_sent, results_checked);
        $display("Seen: %0d inserted, %0d updated, %0d ignored, %0d table full, %0d reads.",
                 action_tally[ACT_INSERTED], action_tally[ACT_UPDATED],
                 action_tally[ACT_IGNORED], action_tally[ACT_FULL], action_tally[ACT_READ]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mnt_pkg.sv
sv/mnt_ram.sv
sv/mesh_neighbor_table.sv
tb/mesh_neighbor_table_test.sv
